>>> hdl/tat_pkg.sv
package tat_pkg;

    localparam int NSETS    = 32;
    localparam int SET_W    = 5;
    localparam int WAY_W    = 2;
    localparam int S_DATA_W = 96;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 88;
    localparam int M_USER_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] CMD_XLATE = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] CFG_MMU_EN    = 2'd0;
    localparam logic [1:0] CFG_INDEX_MD  = 2'd1;
    localparam logic [1:0] CFG_SINGLE_VM = 2'd2;
    localparam logic [1:0] CFG_ASID      = 2'd3;

    localparam logic [3:0] FLT_OK       = 4'd0;
    localparam logic [3:0] FLT_LD_ADDR  = 4'd1;
    localparam logic [3:0] FLT_ST_ADDR  = 4'd2;
    localparam logic [3:0] FLT_LD_MISS  = 4'd3;
    localparam logic [3:0] FLT_ST_MISS  = 4'd4;
    localparam logic [3:0] FLT_LD_INV   = 4'd5;
    localparam logic [3:0] FLT_ST_INV   = 4'd6;
    localparam logic [3:0] FLT_LD_PROT  = 4'd7;
    localparam logic [3:0] FLT_ST_PROT  = 4'd8;
    localparam logic [3:0] FLT_INIT_WR  = 4'd9;

    localparam logic [2:0] REG_P1 = 3'b100;
    localparam logic [2:0] REG_P2 = 3'b101;
    localparam logic [2:0] REG_P4 = 3'b111;

    typedef struct packed {
        logic [16:0] vpn;
        logic [7:0]  asid;
        logic [18:0] ppn;
        logic        valid;
        logic [1:0]  prot;
        logic [3:0]  attr;
    } tlb_entry_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] vaddr;
        logic        is_write;
        logic        privileged;
        logic [1:0]  way;
    } st1_t;

    typedef struct packed {
        logic       mmu_en;
        logic       single_vm;
        logic [7:0] asid;
    } lk_cfg_t;

    typedef struct packed {
        logic [3:0]  fault_code;
        logic [31:0] paddr;
        logic        cacheable;
        tlb_entry_t  rd;
    } result_t;

endpackage

>>> hdl/tat_store.sv
module tat_store #(
    parameter int WAYS = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       acc,
    input  logic                       wr_en,
    input  logic [tat_pkg::SET_W-1:0]  set,
    input  logic [tat_pkg::WAY_W-1:0]  wr_way,
    input  tat_pkg::tlb_entry_t        wdata,
    output tat_pkg::tlb_entry_t        rd_entry [WAYS]
);
    import tat_pkg::*;

    tlb_entry_t        rd_raw_reg [WAYS];
    logic              rd_vld_reg [WAYS];
    logic [NSETS-1:0]  vld_reg    [WAYS];

    for (genvar w = 0; w < WAYS; w++) begin : g_way
        tlb_entry_t mem [NSETS];
        logic       hit_wr;

        assign hit_wr = acc && wr_en && (wr_way == WAY_W'(w));

        always_ff @(posedge aclk) begin
            if (hit_wr) begin
                mem[set] <= wdata;
            end
            if (acc) begin
                rd_raw_reg[w] <= mem[set];
            end
        end

        // per-entry valid bits stand in for the cleared store after reset
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[w]    <= '0;
                rd_vld_reg[w] <= 1'b0;
            end else begin
                if (hit_wr) begin
                    vld_reg[w][set] <= 1'b1;
                end
                if (acc) begin
                    rd_vld_reg[w] <= vld_reg[w][set];
                end
            end
        end

        assign rd_entry[w] = rd_vld_reg[w] ? rd_raw_reg[w] : '0;
    end

endmodule

>>> hdl/tat_lookup.sv
module tat_lookup #(
    parameter int WAYS = 4
) (
    input  tat_pkg::st1_t       st,
    input  tat_pkg::tlb_entry_t entry [WAYS],
    input  tat_pkg::lk_cfg_t    cfg,
    output tat_pkg::result_t    res
);
    import tat_pkg::*;

    logic [WAYS-1:0] hit_vec;
    logic [16:0]     vvpn;
    logic            hit;
    tlb_entry_t      sel;
    tlb_entry_t      rd_sel;

    assign vvpn = {st.vaddr[31:17], st.vaddr[11:10]};

    always_comb begin
        logic vm;
        logic ign;
        for (int w = 0; w < WAYS; w++) begin
            vm  = entry[w].attr[3] ? (entry[w].vpn[16:2] == vvpn[16:2])
                                   : (entry[w].vpn == vvpn);
            ign = entry[w].attr[0] || (st.privileged && cfg.single_vm);
            hit_vec[w] = vm && (ign || (entry[w].asid == cfg.asid));
        end
    end

    // first matching way wins
    always_comb begin
        hit = 1'b0;
        sel = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_vec[w] && !hit) begin
                hit = 1'b1;
                sel = entry[w];
            end
        end
    end

    always_comb begin
        rd_sel = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (st.way == WAY_W'(w)) begin
                rd_sel = entry[w];
            end
        end
    end

    always_comb begin
        logic [31:0] va;
        logic        wr;
        logic        priv;
        logic [3:0]  flt;
        va   = st.vaddr;
        wr   = st.is_write;
        priv = st.privileged;
        flt  = FLT_OK;
        res  = '0;
        case (st.cmd)
            CMD_XLATE: begin
                if (va[31:29] == REG_P4) begin
                    res.paddr = va;
                end else if (!cfg.mmu_en) begin
                    res.paddr     = {3'b000, va[28:0]};
                    res.cacheable = 1'b1;
                end else if (!priv && va[31]) begin
                    res.fault_code = wr ? FLT_ST_ADDR : FLT_LD_ADDR;
                end else if (priv && va[31:29] == REG_P1) begin
                    res.paddr     = {1'b0, va[30:0]};
                    res.cacheable = 1'b1;
                end else if (priv && va[31:29] == REG_P2) begin
                    res.paddr = {3'b000, va[28:0]};
                end else if (!hit) begin
                    res.fault_code = wr ? FLT_ST_MISS : FLT_LD_MISS;
                end else if (!sel.valid) begin
                    res.fault_code = wr ? FLT_ST_INV : FLT_LD_INV;
                end else begin
                    if (!priv) begin
                        if (!sel.prot[1]) begin
                            flt = wr ? FLT_ST_PROT : FLT_LD_PROT;
                        end else if (!sel.prot[0] && wr) begin
                            flt = FLT_ST_PROT;
                        end else if (wr && !sel.attr[1]) begin
                            flt = FLT_INIT_WR;
                        end
                    end else begin
                        if (!sel.prot[0] && wr) begin
                            flt = FLT_ST_PROT;
                        end else if (wr && !sel.attr[1]) begin
                            flt = FLT_INIT_WR;
                        end
                    end
                    res.fault_code = flt;
                    if (flt == FLT_OK) begin
                        res.paddr = sel.attr[3] ? {3'b000, sel.ppn[18:2], va[11:0]}
                                                : {3'b000, sel.ppn, va[9:0]};
                        res.cacheable = sel.attr[2];
                    end
                end
            end
            CMD_READ: begin
                res.rd = rd_sel;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> hdl/tlb_address_translator.sv
// Set-associative TLB (32 sets by WAYS ways) that writes or reads a whole entry, or
// translates one load/store address per beat. One beat is accepted every cycle while
// the result output is not stalled by m_tready; all ways of the indexed set are first
// read from the entry memory into registers, then the way compares, priority pick and
// protection check go into the result register. An entry write is visible to the very
// next beat. All entries read as zero after reset, with no clearing pass. Configuration
// writes (mmu enable, index mode, single-vm, current asid) are taken at any time but must
// only be issued while no beat is in flight.
module tlb_address_translator #(
    parameter int WAYS = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // vaddr, is_write, privileged, set_index, way, ent_vpn, ent_asid, ent_ppn,
    // ent_valid, ent_prot, ent_attr, zero fill
    input  logic [tat_pkg::S_DATA_W-1:0]     s_tdata,
    // cmd
    input  logic [tat_pkg::S_USER_W-1:0]     s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // paddr, cacheable, rd_vpn, rd_asid, rd_ppn, rd_valid, rd_prot, rd_size,
    // rd_cache, rd_dirty, rd_shared, zero fill
    output logic [tat_pkg::M_DATA_W-1:0]     m_tdata,
    // fault_code
    output logic [tat_pkg::M_USER_W-1:0]     m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tat_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tat_pkg::*;

    logic        mmu_en_reg;
    logic        index_md_reg;
    logic        single_vm_reg;
    logic [7:0]  asid_reg;

    logic        st1_valid_reg;
    logic        st1_valid_next;
    st1_t        st1_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    result_t     res_reg;
    result_t     res_next;

    logic        accept;
    logic        adv1;
    logic [1:0]  in_cmd;
    logic [31:0] in_vaddr;
    logic [SET_W-1:0] set_base;
    logic [SET_W-1:0] set_sel;
    tlb_entry_t  in_entry;
    tlb_entry_t  rd_entry [WAYS];
    lk_cfg_t     lk_cfg;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mmu_en_reg    <= 1'b0;
            index_md_reg  <= 1'b0;
            single_vm_reg <= 1'b0;
            asid_reg      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MMU_EN:    mmu_en_reg    <= cfg_data[0];
                CFG_INDEX_MD:  index_md_reg  <= cfg_data[0];
                CFG_SINGLE_VM: single_vm_reg <= cfg_data[0];
                CFG_ASID:      asid_reg      <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input beat decode
    assign in_cmd   = s_tuser;
    assign in_vaddr = s_tdata[31:0];
    assign in_entry = '{vpn:   s_tdata[57:41],
                        asid:  s_tdata[65:58],
                        ppn:   s_tdata[84:66],
                        valid: s_tdata[85],
                        prot:  s_tdata[87:86],
                        attr:  s_tdata[91:88]};

    assign set_base = (in_cmd == CMD_XLATE) ? in_vaddr[16:12] : s_tdata[38:34];
    assign set_sel  = index_md_reg ? (set_base ^ asid_reg[SET_W-1:0]) : set_base;

    // pipeline control
    assign adv1     = !m_valid_reg || m_tready;
    assign s_tready = !st1_valid_reg || adv1;
    assign accept   = s_tvalid && s_tready;

    assign st1_valid_next = accept ? 1'b1 : (adv1 ? 1'b0 : st1_valid_reg);
    assign m_valid_next   = adv1 ? st1_valid_reg : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st1_reg <= '{cmd:        in_cmd,
                         vaddr:      in_vaddr,
                         is_write:   s_tdata[32],
                         privileged: s_tdata[33],
                         way:        s_tdata[40:39]};
        end
        if (adv1 && st1_valid_reg) begin
            res_reg <= res_next;
        end
    end

    tat_store #(
        .WAYS (WAYS)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .acc      (accept),
        .wr_en    (in_cmd == CMD_WRITE),
        .set      (set_sel),
        .wr_way   (s_tdata[40:39]),
        .wdata    (in_entry),
        .rd_entry (rd_entry)
    );

    assign lk_cfg = '{mmu_en: mmu_en_reg, single_vm: single_vm_reg, asid: asid_reg};

    tat_lookup #(
        .WAYS (WAYS)
    ) u_lookup (
        .st    (st1_reg),
        .entry (rd_entry),
        .cfg   (lk_cfg),
        .res   (res_next)
    );

    // result beat
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = res_reg.fault_code;
    assign m_tdata  = {4'b0000,
                       res_reg.rd.attr[0],
                       res_reg.rd.attr[1],
                       res_reg.rd.attr[2],
                       res_reg.rd.attr[3],
                       res_reg.rd.prot,
                       res_reg.rd.valid,
                       res_reg.rd.ppn,
                       res_reg.rd.asid,
                       res_reg.rd.vpn,
                       res_reg.cacheable,
                       res_reg.paddr};

    a_fault_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (res_reg.fault_code != FLT_OK)
        |-> (res_reg.paddr == '0) && !res_reg.cacheable)
        else $error("faulting result carries an address");

    a_read_no_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (res_reg.rd != '0) |-> (res_reg.fault_code == FLT_OK)
            && (res_reg.paddr == '0))
        else $error("entry read result mixed with translation fields");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> st1_valid_reg && m_valid_reg && !m_tready)
        else $error("input stalled while pipeline has room");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg && adv1 |=> m_valid_reg)
        else $error("stage one beat lost on its way to the result register");

endmodule
